// ----- rtl/core/phm_pkg.sv -----
// ----------------------------------------------------------------------------
// Profile histogram mean: shared types and constants
// Item and result layouts, bin store word, memory and divider port groups,
// sequencer states and the fixed-point constants of the bin mapping.
// ----------------------------------------------------------------------------
package phm_pkg;

	// Histogram geometry.
	localparam int NUM_BINS = 100;
	localparam int BIN_W    = 7;

	// Field widths.
	localparam int MOM_W   = 16;
	localparam int SUM_W   = 32;
	localparam int COUNT_W = 16;

	// Longitudinal full scale is 10.0 in Q4.12, i.e. 10 * 2^FRAC_BITS.
	localparam int FRAC_BITS     = 12;
	localparam int PL_FULL_SCALE = 40960;
	localparam int PL_ROUND      = PL_FULL_SCALE - 1;

	// pl * NUM_BINS + PL_ROUND fits in PROD_W bits.
	localparam int PROD_W = 23;
	localparam int Y_W    = PROD_W - FRAC_BITS;

	// Division by ten as a multiply by 205 / 2^11, exact for operands up to 1028.
	localparam int RECIP_10    = 205;
	localparam int RECIP_SHIFT = 11;
	localparam int RECIP_W     = 19;
	localparam int QUOT_W      = RECIP_W - RECIP_SHIFT;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Operation codes.
	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_READ = 1'b1;

	// Divider geometry: one quotient bit per cycle.
	localparam int DIV_STEPS = SUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic             op;
		logic [MOM_W-1:0] long_momentum;
		logic [MOM_W-1:0] trans_momentum;
		logic [BIN_W-1:0] read_bin;
	} in_t;

	typedef struct packed {
		logic               hit;
		logic [BIN_W-1:0]   bin_index;
		logic [MOM_W-1:0]   mean_trans;
		logic [COUNT_W-1:0] sample_count;
		logic               empty_bin;
	} out_t;

	typedef struct packed {
		logic [SUM_W-1:0]   sum;
		logic [COUNT_W-1:0] count;
	} bin_t;

	typedef struct packed {
		logic             rd_en;
		logic             wr_en;
		logic [BIN_W-1:0] addr;
		bin_t             wr_data;
	} mem_req_t;

	typedef struct packed {
		logic               start;
		logic [SUM_W-1:0]   dividend;
		logic [COUNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [MOM_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INDEX,
		ST_ACCESS,
		ST_DIVIDE
	} state_t;

endpackage

// ----- rtl/core/phm_bin_mem.sv -----
// ----------------------------------------------------------------------------
// Profile histogram mean: bin store
// One synchronous memory holding each bin's sum and count, with a registered
// read port. Per-entry valid flags make unwritten bins read as zero.
// ----------------------------------------------------------------------------
module phm_bin_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  phm_pkg::mem_req_t req,
	output phm_pkg::bin_t     rd_data
);

	phm_pkg::bin_t                    mem_q [phm_pkg::NUM_BINS];
	logic [phm_pkg::NUM_BINS-1:0]     valid_q;
	phm_pkg::bin_t                    data_s1;
	logic                             valid_s1;

	// Memory array write and registered read.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			data_s1 <= mem_q[req.addr];
		end
	end

	// Valid flags are cleared by reset and set on the first write of a bin.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.addr] <= 1'b1;
			end
			if (req.rd_en) begin
				valid_s1 <= valid_q[req.addr];
			end
		end
	end

	// A bin never written reads as an empty bin.
	assign rd_data = valid_s1 ? data_s1 : '0;

endmodule

// ----- rtl/core/phm_div.sv -----
// ----------------------------------------------------------------------------
// Profile histogram mean: mean divider
// Restoring radix-2 divider, one quotient bit per cycle, 32-bit sum by
// 16-bit count. The quotient is saturated to the 16-bit mean field.
// ----------------------------------------------------------------------------
module phm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  phm_pkg::div_req_t req,
	output phm_pkg::div_rsp_t rsp
);

	logic                           run_q;
	logic                           done_q;
	logic [phm_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [phm_pkg::SUM_W-1:0]      quo_q;
	logic [phm_pkg::COUNT_W-1:0]    rem_q;
	logic [phm_pkg::COUNT_W-1:0]    dvs_q;

	logic [phm_pkg::COUNT_W:0]      trial;
	logic                           ge;
	logic [phm_pkg::COUNT_W:0]      diff;
	logic                           last;

	// One restoring step: shift in the next dividend bit and try a subtract.
	always_comb begin
		trial = {rem_q, quo_q[phm_pkg::SUM_W-1]};
		ge    = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
		last  = cnt_q == phm_pkg::DIV_CNT_W'(phm_pkg::DIV_STEPS - 1);
	end

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && last;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: the dividend register fills with quotient bits from the bottom.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[phm_pkg::SUM_W-2:0], ge};
			rem_q <= ge ? diff[phm_pkg::COUNT_W-1:0] : trial[phm_pkg::COUNT_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = (|quo_q[phm_pkg::SUM_W-1:phm_pkg::MOM_W]) ? '1
		: quo_q[phm_pkg::MOM_W-1:0];

endmodule

// ----- rtl/core/profile_histogram_mean_unit.sv -----
// ----------------------------------------------------------------------------
// Profile histogram mean unit
// Flow: a sample or a read of a non-empty bin shows its result after the
// divider has run; a missed sample or an empty or invalid read skips it.
// One item at a time; the next start is taken in the done cycle, and a
// sample's time is set by the 32 steps of the radix-2 divider.
// Reset: all bins read as zero after reset; the result strobe cannot be held.
// ----------------------------------------------------------------------------
module profile_histogram_mean_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  phm_pkg::in_t  item,
	output logic          done,
	output phm_pkg::out_t result
);

	phm_pkg::state_t               state_q;
	phm_pkg::state_t               state_d;

	phm_pkg::in_t                  item_q;
	logic [phm_pkg::PROD_W-1:0]    prod_q;
	logic                          inrange_q;
	logic [phm_pkg::BIN_W-1:0]     bin_q;
	logic [phm_pkg::COUNT_W-1:0]   count_q;
	phm_pkg::out_t                 result_q;
	logic                          done_q;

	phm_pkg::mem_req_t             mem_req;
	phm_pkg::bin_t                 rd_data;
	phm_pkg::div_req_t             div_req;
	phm_pkg::div_rsp_t             div_rsp;

	logic                          accept;
	logic [phm_pkg::Y_W-1:0]       pl_y;
	logic [phm_pkg::RECIP_W-1:0]   recip;
	logic [phm_pkg::QUOT_W-1:0]    calc_q;
	logic [phm_pkg::QUOT_W-1:0]    calc_qm1;
	logic [phm_pkg::BIN_W-1:0]     sel_bin;
	logic                          sel_hit;
	logic                          full;
	logic [phm_pkg::SUM_W:0]       sum_add;
	logic [phm_pkg::COUNT_W-1:0]   cnt_sel;
	logic                          emit;
	phm_pkg::out_t                 emit_val;

	assign accept = start && !busy;
	assign busy   = state_q != phm_pkg::ST_IDLE;

	// Bin store and mean divider.
	phm_bin_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	phm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Capture the beat and form pl * NUM_BINS + (full scale - 1) for the ceiling.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q    <= item;
			prod_q    <= phm_pkg::PROD_W'(item.long_momentum) * phm_pkg::PROD_W'(phm_pkg::NUM_BINS)
				+ phm_pkg::PROD_W'(phm_pkg::PL_ROUND);
			inrange_q <= (item.long_momentum != '0)
				&& (item.long_momentum <= phm_pkg::MOM_W'(phm_pkg::PL_FULL_SCALE));
		end
	end

	// Bin number: drop the 2^12 factor of the full scale, then divide by ten.
	always_comb begin
		pl_y     = prod_q[phm_pkg::PROD_W-1:phm_pkg::FRAC_BITS];
		recip    = phm_pkg::RECIP_W'(pl_y) * phm_pkg::RECIP_W'(phm_pkg::RECIP_10);
		calc_q   = recip[phm_pkg::RECIP_W-1:phm_pkg::RECIP_SHIFT];
		calc_qm1 = calc_q - 1'b1;
		if (item_q.op == phm_pkg::OP_ADD) begin
			sel_hit = inrange_q;
			sel_bin = calc_qm1[phm_pkg::BIN_W-1:0];
		end else begin
			sel_hit = item_q.read_bin < phm_pkg::BIN_W'(phm_pkg::NUM_BINS);
			sel_bin = item_q.read_bin;
		end
	end

	// Saturating bin update and the count that goes with the result.
	always_comb begin
		full    = rd_data.count == phm_pkg::COUNT_MAX;
		sum_add = {1'b0, rd_data.sum} + (phm_pkg::SUM_W + 1)'(item_q.trans_momentum);
		if (item_q.op == phm_pkg::OP_ADD && !full) begin
			cnt_sel = rd_data.count + 1'b1;
		end else begin
			cnt_sel = rd_data.count;
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= phm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state, memory access, divider start and result load.
	always_comb begin
		state_d  = state_q;
		mem_req  = '0;
		div_req  = '0;
		emit     = 1'b0;
		emit_val = '0;
		unique case (state_q)
			phm_pkg::ST_IDLE: begin
				if (start) begin
					state_d = phm_pkg::ST_INDEX;
				end
			end
			phm_pkg::ST_INDEX: begin
				if (sel_hit) begin
					mem_req.rd_en = 1'b1;
					mem_req.addr  = sel_bin;
					state_d       = phm_pkg::ST_ACCESS;
				end else begin
					// Missed sample or out-of-range read.
					emit = 1'b1;
					if (item_q.op == phm_pkg::OP_READ) begin
						emit_val.bin_index = item_q.read_bin;
					end
					state_d = phm_pkg::ST_IDLE;
				end
			end
			phm_pkg::ST_ACCESS: begin
				if (item_q.op == phm_pkg::OP_ADD) begin
					mem_req.wr_en         = !full;
					mem_req.addr          = bin_q;
					mem_req.wr_data.count = cnt_sel;
					mem_req.wr_data.sum   = sum_add[phm_pkg::SUM_W] ? '1
						: sum_add[phm_pkg::SUM_W-1:0];
					div_req.start    = 1'b1;
					div_req.dividend = full ? rd_data.sum : mem_req.wr_data.sum;
					div_req.divisor  = cnt_sel;
					state_d          = phm_pkg::ST_DIVIDE;
				end else if (rd_data.count == '0) begin
					// Read of an empty bin.
					emit               = 1'b1;
					emit_val.hit       = 1'b1;
					emit_val.bin_index = bin_q;
					emit_val.empty_bin = 1'b1;
					state_d            = phm_pkg::ST_IDLE;
				end else begin
					div_req.start    = 1'b1;
					div_req.dividend = rd_data.sum;
					div_req.divisor  = rd_data.count;
					state_d          = phm_pkg::ST_DIVIDE;
				end
			end
			phm_pkg::ST_DIVIDE: begin
				if (div_rsp.done) begin
					emit                  = 1'b1;
					emit_val.hit          = 1'b1;
					emit_val.bin_index    = bin_q;
					emit_val.mean_trans   = div_rsp.quotient;
					emit_val.sample_count = count_q;
					state_d               = phm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = phm_pkg::ST_IDLE;
			end
		endcase
	end

	// Bin and count held across the access and the division.
	always_ff @(posedge clk) begin
		if (state_q == phm_pkg::ST_INDEX) begin
			bin_q <= sel_bin;
		end
		if (state_q == phm_pkg::ST_ACCESS) begin
			count_q <= cnt_sel;
		end
		if (emit) begin
			result_q <= emit_val;
		end
	end

	// One-cycle result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= emit;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// A result beat always comes with the sequencer back at rest.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// An accepted beat always starts the sequencer.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted beat did not start the sequencer");

	// Writes only ever land inside the histogram.
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |-> (mem_req.addr < phm_pkg::BIN_W'(phm_pkg::NUM_BINS)))
		else $error("bin write outside the histogram");

	// The divider is never started with a zero count.
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> (div_req.divisor != '0))
		else $error("divider started with zero count");

	// An empty flag comes only with a valid read of a zero count.
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.empty_bin |-> result.hit && (result.sample_count == '0))
		else $error("empty flag on a non-empty result");

endmodule

// ----- tb/profile_histogram_mean_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Profile histogram mean unit testbench
// Drives add and read items through the start/busy handshake and keeps its own
// copy of the per-bin sums and counts. Every result beat is checked field by
// field against the oldest predicted result. The directed part covers the bin
// edges, out-of-range samples, empty and invalid reads and one bin filled deep
// with back-to-back samples. The random part is mostly in-range samples and
// valid reads.
// ----------------------------------------------------------------------------
module profile_histogram_mean_unit_tb;

	// Samples sent back to back into one bin by the deep-bin test.
	localparam int DEEP_FILL = 200;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	logic          done;
	phm_pkg::in_t  item;
	phm_pkg::out_t result;

	profile_histogram_mean_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	// Predicted bin store and the queue of results still to come.
	logic [phm_pkg::SUM_W-1:0]   bin_sum [phm_pkg::NUM_BINS];
	logic [phm_pkg::COUNT_W-1:0] bin_cnt [phm_pkg::NUM_BINS];
	phm_pkg::out_t               pending_results [$];

	int errors;
	int n_in_range;
	int n_out_range;
	int n_reads;
	int n_empty_reads;
	int deep_bin;

	// Truncated mean of one predicted bin, saturated to the field width.
	function automatic logic [phm_pkg::MOM_W-1:0] bin_mean(int k);
		logic [phm_pkg::SUM_W-1:0] m;
		if (bin_cnt[k] == '0) begin
			return '0;
		end
		m = bin_sum[k] / bin_cnt[k];
		return (m > 32'h0000_FFFF) ? '1 : m[phm_pkg::MOM_W-1:0];
	endfunction

	// Applies one accepted item to the predicted store and returns its result.
	function automatic phm_pkg::out_t predict_histogram(phm_pkg::in_t it);
		phm_pkg::out_t           r;
		int                      k;
		logic [phm_pkg::SUM_W:0] s;
		r = '0;
		if (it.op == phm_pkg::OP_ADD) begin
			if (it.long_momentum != '0
					&& int'(it.long_momentum) <= phm_pkg::PL_FULL_SCALE) begin
				k = (int'(it.long_momentum) * phm_pkg::NUM_BINS + phm_pkg::PL_ROUND)
					/ phm_pkg::PL_FULL_SCALE - 1;
				if (bin_cnt[k] != phm_pkg::COUNT_MAX) begin
					s = {1'b0, bin_sum[k]} + it.trans_momentum;
					bin_sum[k] = s[phm_pkg::SUM_W] ? '1 : s[phm_pkg::SUM_W-1:0];
					bin_cnt[k] = bin_cnt[k] + 1'b1;
				end
				r.hit          = 1'b1;
				r.bin_index    = k[phm_pkg::BIN_W-1:0];
				r.mean_trans   = bin_mean(k);
				r.sample_count = bin_cnt[k];
				n_in_range++;
			end else begin
				n_out_range++;
			end
		end else begin
			n_reads++;
			r.bin_index = it.read_bin;
			if (int'(it.read_bin) < phm_pkg::NUM_BINS) begin
				r.hit          = 1'b1;
				r.sample_count = bin_cnt[it.read_bin];
				if (bin_cnt[it.read_bin] == '0) begin
					r.empty_bin = 1'b1;
					n_empty_reads++;
				end else begin
					r.mean_trans = bin_mean(int'(it.read_bin));
				end
			end
		end
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// Clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Records each accepted item beat and checks each result beat.
	always @(posedge clk) begin : result_check
		phm_pkg::out_t want;
		if (arst_n) begin
			if (start && !busy) begin
				pending_results.push_back(predict_histogram(item));
			end
			if (done) begin
				if (pending_results.size() == 0) begin
					$error("result beat with nothing outstanding: bin_index %0d",
						result.bin_index);
					errors++;
				end else begin
					want = pending_results.pop_front();
					check_field("hit", want.hit, result.hit);
					check_field("bin_index", want.bin_index, result.bin_index);
					check_field("mean_trans", want.mean_trans, result.mean_trans);
					check_field("sample_count", want.sample_count, result.sample_count);
					check_field("empty_bin", want.empty_bin, result.empty_bin);
				end
			end
		end
	end

	function automatic phm_pkg::in_t make_item(logic op, int pl, int pt, int rb);
		phm_pkg::in_t it;
		it.op             = op;
		it.long_momentum  = pl[phm_pkg::MOM_W-1:0];
		it.trans_momentum = pt[phm_pkg::MOM_W-1:0];
		it.read_bin       = rb[phm_pkg::BIN_W-1:0];
		return it;
	endfunction

	// Random item: mostly in-range samples and valid reads, some misses and
	// invalid reads, with a hot region at low momentum to build deep bins.
	function automatic phm_pkg::in_t random_item();
		int  r;
		int  pl;
		int  pt;
		int  rb;
		logic op;
		r  = $urandom_range(0, 99);
		op = ($urandom_range(0, 99) < 30) ? phm_pkg::OP_READ : phm_pkg::OP_ADD;
		if (r < 4) begin
			pl = 0;
		end else if (r < 10) begin
			pl = $urandom_range(phm_pkg::PL_FULL_SCALE + 1, 65535);
		end else if (r < 40) begin
			pl = $urandom_range(1, 2048);
		end else begin
			pl = $urandom_range(1, phm_pkg::PL_FULL_SCALE);
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			pt = 0;
		end else if (r < 10) begin
			pt = phm_pkg::PL_FULL_SCALE;
		end else begin
			pt = $urandom_range(0, phm_pkg::PL_FULL_SCALE);
		end
		if ($urandom_range(0, 99) < 10) begin
			rb = $urandom_range(phm_pkg::NUM_BINS, 127);
		end else if ($urandom_range(0, 1) == 0) begin
			rb = $urandom_range(0, 4);
		end else begin
			rb = $urandom_range(0, phm_pkg::NUM_BINS - 1);
		end
		return make_item(op, pl, pt, rb);
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Sends one item beat, then idles for the given gap with noise on the bus.
	// With a gap of zero start stays high for the next item.
	task automatic send_item(input phm_pkg::in_t it, input int gap);
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
		if (gap > 0) begin
			start <= 1'b0;
			item  <= random_item();
			repeat (gap) @(posedge clk);
		end
	endtask

	// Holds off the sender until every predicted result has arrived.
	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Samples on both sides of the bin edges, plus the three kinds of miss.
	task automatic test_bin_edges();
		send_item(make_item(phm_pkg::OP_ADD, 1, 0, 0), random_gap());
		send_item(make_item(phm_pkg::OP_ADD, 409, phm_pkg::PL_FULL_SCALE, 127),
			random_gap());
		send_item(make_item(phm_pkg::OP_ADD, 409, 4097, 0), 0);
		send_item(make_item(phm_pkg::OP_ADD, 410, 12345, 0), 0);
		send_item(make_item(phm_pkg::OP_ADD, 20480, 32768, 0), random_gap());
		send_item(make_item(phm_pkg::OP_ADD, 40959, 1, 0), random_gap());
		send_item(make_item(phm_pkg::OP_ADD, phm_pkg::PL_FULL_SCALE,
			phm_pkg::PL_FULL_SCALE, 0), 0);
		send_item(make_item(phm_pkg::OP_ADD, phm_pkg::PL_FULL_SCALE, 0, 0), random_gap());
		send_item(make_item(phm_pkg::OP_ADD, 0, phm_pkg::PL_FULL_SCALE, 99), random_gap());
		send_item(make_item(phm_pkg::OP_ADD, phm_pkg::PL_FULL_SCALE + 1, 100, 0), 0);
		send_item(make_item(phm_pkg::OP_ADD, 65535, 65535, 127), random_gap());
	endtask

	// Reads of filled, empty and out-of-range bins.
	task automatic test_read_cases();
		send_item(make_item(phm_pkg::OP_READ, 0, 0, 0), 0);
		send_item(make_item(phm_pkg::OP_READ, 65535, 65535, 1), random_gap());
		send_item(make_item(phm_pkg::OP_READ, 0, 0, 50), random_gap());
		send_item(make_item(phm_pkg::OP_READ, 0, 0, 99), 0);
		send_item(make_item(phm_pkg::OP_READ, 0, 0, phm_pkg::NUM_BINS), 0);
		send_item(make_item(phm_pkg::OP_READ, 0, 0, 127), random_gap());
		send_item(make_item(phm_pkg::OP_READ, 0, 0, 2), random_gap());
	endtask

	// Fills one bin deep with back-to-back samples, then reads it.
	task automatic test_deep_bin();
		int pl;
		deep_bin = $urandom_range(0, phm_pkg::NUM_BINS - 1);
		pl       = deep_bin * phm_pkg::PL_FULL_SCALE / phm_pkg::NUM_BINS + 1;
		wait_drained();
		repeat (DEEP_FILL) begin
			send_item(make_item(phm_pkg::OP_ADD, pl,
				$urandom_range(0, phm_pkg::PL_FULL_SCALE), 0), 0);
		end
		send_item(make_item(phm_pkg::OP_READ, 0, 0, deep_bin), random_gap());
	endtask

	// Random items, in runs with and without idling, pausing for a drain now
	// and then.
	task automatic test_random(input int count);
		bit no_idle;
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0) begin
				no_idle = ($urandom_range(0, 3) == 0);
			end
			if (i % 400 == 399) begin
				wait_drained();
			end
			send_item(random_item(), no_idle ? 0 : random_gap());
		end
	endtask

	// Time limit, far above the slowest correct run.
	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		errors        = 0;
		n_in_range    = 0;
		n_out_range   = 0;
		n_reads       = 0;
		n_empty_reads = 0;
		deep_bin      = 0;
		for (int k = 0; k < phm_pkg::NUM_BINS; k++) begin
			bin_sum[k] = '0;
			bin_cnt[k] = '0;
		end
		arst_n = 1'b0;
		start  = 1'b0;
		item   = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_bin_edges();
		test_read_cases();
		wait_drained();
		test_deep_bin();
		test_random(1630);

		wait_drained();
		repeat (60) @(posedge clk);
		$display("Run covered %0d samples in range, %0d out of range, %0d reads (%0d empty).",
			n_in_range, n_out_range, n_reads, n_empty_reads);
		$display("Bin %0d took %0d back-to-back samples before it was read.",
			deep_bin, DEEP_FILL);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			if (pending_results.size() != 0) begin
				$error("%0d predicted results never arrived", pending_results.size());
			end
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
